[rtl/gtg_pkg.sv]
// gtg_pkg: shared types, constants and the arctangent table for the
// go-to-goal velocity controller. No dependencies.
package gtg_pkg;

	// datapath widths of the vectoring unit and the shared multiplier
	localparam int XY_W = 28;
	localparam int Z_W  = 21;
	localparam int MA_W = 28;
	localparam int MB_W = 17;
	localparam int MP_W = MA_W + MB_W;

	typedef enum logic [1:0] {
		CMD_GOAL = 2'd0,
		CMD_POSE = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam logic [0:0] REG_LIN_GAIN = 1'b0;
	localparam logic [0:0] REG_ANG_GAIN = 1'b1;

	localparam logic [11:0] LIN_GAIN_RST = 12'd384;
	localparam logic [11:0] ANG_GAIN_RST = 12'd1024;

	localparam logic signed [Z_W-1:0]  PI_Q16   = 21'sd205887;
	localparam logic signed [MB_W-1:0] INVK_Q16 = 17'sd39797;

	localparam logic signed [28:0] LIN_MAX  = 29'sd16777215;
	localparam logic signed [32:0] TURN_MAX = 33'sd8388607;
	localparam logic signed [32:0] TURN_MIN = -33'sd8388608;

	// vectoring result handed from the iterative unit to the sequencer
	typedef struct packed {
		logic                   done;
		logic signed [XY_W-1:0] x;
		logic signed [Z_W-1:0]  z;
	} cordic_res_t;

	// atan(2^-i) in radians, 16 fraction bits
	function automatic logic [15:0] atan_lut(input logic [4:0] idx);
		logic [15:0] v;
		unique case (idx)
			5'd0:  v = 16'd51472;
			5'd1:  v = 16'd30385;
			5'd2:  v = 16'd16055;
			5'd3:  v = 16'd8150;
			5'd4:  v = 16'd4091;
			5'd5:  v = 16'd2047;
			5'd6:  v = 16'd1024;
			5'd7:  v = 16'd512;
			5'd8:  v = 16'd256;
			5'd9:  v = 16'd128;
			5'd10: v = 16'd64;
			5'd11: v = 16'd32;
			5'd12: v = 16'd16;
			5'd13: v = 16'd8;
			5'd14: v = 16'd4;
			5'd15: v = 16'd2;
			5'd16: v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/gtg_cordic.sv]
// gtg_cordic: iterative vectoring CORDIC, one micro-rotation per cycle.
// Depends on gtg_pkg for widths, the arctangent table and the result struct.
module gtg_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [16:0]       dx,
	input  logic signed [16:0]       dy,
	output gtg_pkg::cordic_res_t     res
);
	import gtg_pkg::*;

	localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   zero_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;

	logic signed [XY_W-1:0] x0;
	logic signed [XY_W-1:0] y0;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  da;
	logic                   last;

	assign x0 = {{3{dx[16]}}, dx, 8'd0};
	assign y0 = {{3{dy[16]}}, dy, 8'd0};
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign da = Z_W'(atan_lut(5'(cnt_q)));
	assign last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == 17'sd0) && (dy == 17'sd0);
			// left half plane: flip the vector and start from +/- pi
			if (dx[16]) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= dy[16] ? -PI_Q16 : PI_Q16;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q[XY_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + da;
			end
		end
	end

	assign res.done = done_q;
	assign res.x    = zero_q ? '0 : x_q;
	assign res.z    = zero_q ? '0 : z_q;

endmodule

[rtl/gtg_mul.sv]
// gtg_mul: shared signed multiplier with a registered product.
// Depends on gtg_pkg for operand widths.
module gtg_mul (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [gtg_pkg::MA_W-1:0] a,
	input  logic signed [gtg_pkg::MB_W-1:0] b,
	output logic signed [gtg_pkg::MP_W-1:0] p_q
);
	import gtg_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MP_W'(a) * MP_W'(b);
		end
	end

endmodule

[rtl/go_to_goal_velocity_controller_top.sv]
// Go-to-goal velocity controller top level: pose storage, sequencer and
// output register. Depends on gtg_pkg, gtg_cordic and gtg_mul.
//
// Usage:
//   Input channel (in_valid / in_stall) carries command, pos_x, pos_y and
//   heading. A goal or own pose transaction just updates the stored pose.
//   A control tick runs one vectoring pass and then three products on the
//   shared multiplier, and gives one output transaction (out_valid /
//   out_stall) with linear_speed and turn_rate. in_stall stays high from
//   the acceptance of a tick until its result enters the output register,
//   so no new transaction is taken while a tick is still in progress.
//   A finished result sits in the output register until out_stall drops; a
//   later tick that finishes while it still waits holds in its last step.
//   The user must write gains through cfg_we / cfg_index / cfg_data only
//   while idle; the block itself does not enforce it. Reset clears the
//   poses, restores both gains to their defaults, and leaves the block idle with no result pending.
module go_to_goal_velocity_controller_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [23:0]        linear_speed,
	output logic signed [23:0] turn_rate,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [11:0]        cfg_data
);
	import gtg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CORDIC,
		S_MAG,
		S_LIN,
		S_TURN,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [11:0]        lin_gain_q;
	logic [11:0]        ang_gain_q;
	logic signed [15:0] goal_x_q;
	logic signed [15:0] goal_y_q;
	logic signed [15:0] own_x_q;
	logic signed [15:0] own_y_q;
	logic signed [15:0] own_heading_q;
	logic signed [17:0] err_q;
	logic [23:0]        lin_q;
	logic               out_valid_q;
	logic [23:0]        linear_speed_q;
	logic signed [23:0] turn_rate_q;

	logic                   in_acc;
	logic                   start;
	logic signed [16:0]     dx;
	logic signed [16:0]     dy;
	cordic_res_t            cres;
	logic                   mul_en;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] mul_p;
	logic signed [16:0]     ang;
	logic signed [17:0]     err;
	logic signed [28:0]     scaled16;
	logic signed [32:0]     turn_w;
	logic [23:0]            lin_sat;
	logic signed [23:0]     turn_sat;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign start    = in_acc && (cmd_t'(command) == CMD_TICK);

	assign dx = 17'(goal_x_q) - 17'(own_x_q);
	assign dy = 17'(goal_y_q) - 17'(own_y_q);

	gtg_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.dx    (dx),
		.dy    (dy),
		.res   (cres)
	);

	// angle rounded to Q3.12, error against own heading
	assign ang = 17'((cres.z + 21'sd8) >>> 4);
	assign err = 18'(ang) - 18'(own_heading_q);

	assign scaled16 = 29'(mul_p >>> 16);
	assign turn_w   = 33'(mul_p >>> 12);

	always_comb begin
		mul_en = 1'b0;
		mul_a  = MA_W'(err_q);
		mul_b  = MB_W'($signed({1'b0, ang_gain_q}));
		unique case (state_q)
			S_MAG: begin
				mul_en = 1'b1;
				mul_a  = cres.x;
				mul_b  = INVK_Q16;
			end
			S_LIN: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(scaled16);
				mul_b  = MB_W'($signed({1'b0, lin_gain_q}));
			end
			S_TURN: begin
				mul_en = 1'b1;
			end
			S_IDLE, S_CORDIC, S_OUT: begin
				mul_en = 1'b0;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	gtg_mul u_mul (
		.clk(clk),
		.en (mul_en),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(mul_p)
	);

	always_comb begin
		if (scaled16 < 29'sd0) begin
			lin_sat = '0;
		end else if (scaled16 > LIN_MAX) begin
			lin_sat = '1;
		end else begin
			lin_sat = scaled16[23:0];
		end
	end

	always_comb begin
		if (turn_w > TURN_MAX) begin
			turn_sat = 24'sh7fffff;
		end else if (turn_w < TURN_MIN) begin
			turn_sat = -24'sh800000;
		end else begin
			turn_sat = turn_w[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q <= LIN_GAIN_RST;
			ang_gain_q <= ANG_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIN_GAIN: lin_gain_q <= cfg_data;
				REG_ANG_GAIN: ang_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q      <= '0;
			goal_y_q      <= '0;
			own_x_q       <= '0;
			own_y_q       <= '0;
			own_heading_q <= '0;
		end else if (in_acc) begin
			unique case (cmd_t'(command))
				CMD_GOAL: begin
					goal_x_q <= pos_x;
					goal_y_q <= pos_y;
				end
				CMD_POSE: begin
					own_x_q       <= pos_x;
					own_y_q       <= pos_y;
					own_heading_q <= heading;
				end
				CMD_TICK, CMD_NONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a result leaving while the next one finishes is replaced in S_OUT
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CORDIC;
					end
				end
				S_CORDIC: begin
					if (cres.done) begin
						state_q <= S_MAG;
					end
				end
				S_MAG:  state_q <= S_LIN;
				S_LIN:  state_q <= S_TURN;
				S_TURN: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MAG) begin
			err_q <= err;
		end
		if (state_q == S_TURN) begin
			lin_q <= lin_sat;
		end
		if ((state_q == S_OUT) && (!out_valid_q || !out_stall)) begin
			linear_speed_q <= lin_q;
			turn_rate_q    <= turn_sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign linear_speed = linear_speed_q;
	assign turn_rate    = turn_rate_q;

endmodule

[rtl/gtg_checker.sv]
// gtg_checker: port-level assertions for the go-to-goal controller top,
// attached by bind. Depends on gtg_pkg and the top level's ports.
module gtg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         command,
	input logic               out_valid,
	input logic               out_stall,
	input logic [23:0]        linear_speed,
	input logic signed [23:0] turn_rate
);
	import gtg_pkg::*;

	// a waiting result is neither dropped nor altered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(linear_speed) && $stable(turn_rate))
		else $error("result changed or dropped while stalled");

	// a tick keeps the input side busy while it is computed
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_TICK) |=> in_stall)
		else $error("tick accepted but block not busy");

	// a new result only appears at the end of a busy span
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a tick in progress");

	// pose updates never produce a result on the next cycle
	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command != CMD_TICK) && !out_valid |=> !out_valid)
		else $error("update transaction produced a result");

endmodule

bind go_to_goal_velocity_controller_top gtg_checker u_gtg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.command     (command),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.linear_speed(linear_speed),
	.turn_rate   (turn_rate)
);

[sim/go_to_goal_velocity_controller_top_tb.sv]
// Testbench for go_to_goal_velocity_controller_top: directed and random pose/tick
// traffic checked against an in-bench fixed-point go-to-goal predictor.
// Depends on gtg_pkg and the controller RTL.
`timescale 1ns / 100ps

module go_to_goal_velocity_controller_top_tb;
	import gtg_pkg::*;

	localparam int STEPS       = 16;
	localparam int SETTLE      = STEPS + 10;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [23:0]        lin;
		logic signed [23:0] turn;
	} speed_cmd_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         command;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] heading;
	logic               out_valid;
	logic               out_stall;
	logic [23:0]        linear_speed;
	logic signed [23:0] turn_rate;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [11:0]        cfg_data;

	// predictor state
	logic signed [15:0] tgt_x, tgt_y, self_x, self_y, self_hdg;
	logic [11:0]        lin_gain, ang_gain;
	speed_cmd_t         speed_cmds_due[$];
	longint             arctan_q16[24];

	int  mismatch_count = 0;
	int  cycle_count = 0;
	bit  quiet;

	go_to_goal_velocity_controller_top #(
		.CORDIC_STEPS(STEPS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.heading     (heading),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.linear_speed(linear_speed),
		.turn_rate   (turn_rate),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// speed command for the current poses and gains
	function automatic speed_cmd_t compute_speed_cmd();
		speed_cmd_t r;
		longint dx, dy, x, y, z, xs, ys, mag, ang, err, lin, turn;
		dx = longint'(tgt_x) - longint'(self_x);
		dy = longint'(tgt_y) - longint'(self_y);
		if (dx == 0 && dy == 0) begin
			mag = 0;
			ang = 0;
		end else begin
			x = dx * 256;
			y = dy * 256;
			z = 0;
			// left half plane: flip onto the right and start from +/- pi
			if (x < 0) begin
				x = -x;
				y = -y;
				z = (dy >= 0) ? 205887 : -205887;
			end
			for (int i = 0; i < STEPS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y < 0) begin
					x = x - ys;
					y = y + xs;
					z = z - arctan_q16[i];
				end else begin
					x = x + ys;
					y = y - xs;
					z = z + arctan_q16[i];
				end
			end
			mag = (x * 39797) >>> 16;
			ang = (z + 8) >>> 4;
		end
		lin = (longint'(lin_gain) * mag) >>> 16;
		if (lin < 0) lin = 0;
		if (lin > 16777215) lin = 16777215;
		err  = ang - longint'(self_hdg);
		turn = (longint'(ang_gain) * err) >>> 12;
		if (turn > 8388607) turn = 8388607;
		if (turn < -8388608) turn = -8388608;
		r.lin  = lin[23:0];
		r.turn = turn[23:0];
		return r;
	endfunction

	// one input transaction; valid is left high for a following item
	task automatic send_item(input cmd_t cmd, input logic [15:0] px, input logic [15:0] py,
			input logic [15:0] hd);
		if (!quiet && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		pos_x    <= px;
		pos_y    <= py;
		heading  <= hd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		case (cmd)
			CMD_GOAL: begin
				tgt_x = px;
				tgt_y = py;
			end
			CMD_POSE: begin
				self_x   = px;
				self_y   = py;
				self_hdg = hd;
			end
			CMD_TICK: speed_cmds_due.push_back(compute_speed_cmd());
			default: ;
		endcase
	endtask

	// drop valid, let every expected result drain, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (speed_cmds_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_gains(input logic [11:0] lin_val, input logic [11:0] ang_val);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LIN_GAIN;
		cfg_data  <= lin_val;
		@(posedge clk);
		cfg_index <= REG_ANG_GAIN;
		cfg_data  <= ang_val;
		@(posedge clk);
		cfg_we   <= 1'b0;
		lin_gain = lin_val;
		ang_gain = ang_val;
	endtask

	function automatic logic [15:0] rand_coord();
		logic [15:0] v;
		case ($urandom_range(3))
			0: v = 16'($signed($urandom_range(2048)) - 1024);
			1: case ($urandom_range(3))
				0: v = 16'h8000;
				1: v = 16'h7fff;
				2: v = 16'h0000;
				default: v = 16'hffff;
			endcase
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic test_reset_defaults();
		// poses all zero: zero offset, zero heading
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		wait_idle();
	endtask

	task automatic test_directed_geometry();
		send_item(CMD_GOAL, 16'h7fff, 16'h7fff, 16'($urandom));
		send_item(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
		send_item(CMD_POSE, 16'h8000, 16'h8000, 16'h7fff);
		send_item(CMD_TICK, 16'hffff, 16'hffff, 16'hffff);
		// goal behind, above: accumulator starts at +pi
		send_item(CMD_GOAL, 16'h8000, 16'd100, 16'($urandom));
		send_item(CMD_POSE, 16'h7fff, -16'sd5, 16'h8000);
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		// goal behind, below: starts at -pi
		send_item(CMD_GOAL, 16'h8000, 16'h8000, 16'($urandom));
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		// unused command must leave the poses alone
		send_item(CMD_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		// goal straight behind on the x axis
		send_item(CMD_GOAL, -16'sd100, -16'sd5, 16'($urandom));
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		// goal straight below
		send_item(CMD_GOAL, 16'h7fff, -16'sd1000, 16'($urandom));
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		// goal on top of own position with a nonzero heading
		send_item(CMD_GOAL, 16'h7fff, -16'sd5, 16'($urandom));
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		send_item(CMD_POSE, 16'h7fff, -16'sd5, 16'h7fff);
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		wait_idle();
	endtask

	task automatic test_gain_extremes();
		write_gains(12'd0, 12'd0);
		send_item(CMD_GOAL, 16'h8000, 16'h7fff, 16'($urandom));
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		wait_idle();
		write_gains(12'hfff, 12'hfff);
		send_item(CMD_POSE, 16'h7fff, 16'h8000, 16'h8000);
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		send_item(CMD_POSE, 16'h7fff, 16'h8000, 16'h7fff);
		send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		wait_idle();
	endtask

	task automatic run_random_phase(input int n_items);
		int sent;
		int pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_item(CMD_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				if (pick < 30)
					send_item(CMD_GOAL, rand_coord(), rand_coord(), 16'($urandom));
				else if (pick < 37)
					send_item(CMD_POSE, tgt_x, tgt_y, 16'($urandom));
				else if (pick < 60)
					send_item(CMD_POSE, rand_coord(), rand_coord(), rand_coord());
				else
					send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
				sent++;
			end
		end
		wait_idle();
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_gains(12'($urandom), 12'($urandom));
				1: write_gains(12'hfff, 12'd0);
				2: write_gains(12'd0, 12'hfff);
				default: write_gains(LIN_GAIN_RST, 12'($urandom));
			endcase
			// one phase runs with no idling on either side
			quiet = (ph == 2);
			run_random_phase(100);
		end
		quiet = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		speed_cmd_t exp_cmd;
		if (arst_n && out_valid && !out_stall) begin
			if (speed_cmds_due.size() == 0) begin
				$display("%0t: unexpected transaction lin=%0d turn=%0d",
					$time, linear_speed, turn_rate);
				mismatch_count++;
			end else begin
				exp_cmd = speed_cmds_due.pop_front();
				if (linear_speed !== exp_cmd.lin) begin
					$display("%0t: linear_speed expected %0d actual %0d",
						$time, exp_cmd.lin, linear_speed);
					mismatch_count++;
				end
				if (turn_rate !== exp_cmd.turn) begin
					$display("%0t: turn_rate expected %0d actual %0d",
						$time, exp_cmd.turn, turn_rate);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 12);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arctan_q16 = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
		quiet          = 1'b0;
		tgt_x    = '0;
		tgt_y    = '0;
		self_x   = '0;
		self_y   = '0;
		self_hdg = '0;
		lin_gain = LIN_GAIN_RST;
		ang_gain = ANG_GAIN_RST;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= CMD_NONE;
		pos_x     <= '0;
		pos_y     <= '0;
		heading   <= '0;
		out_stall <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_LIN_GAIN;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_directed_geometry();
		test_gain_extremes();
		test_random_traffic();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
